### rtl/bhs_pkg.sv
// Shared types and constants for the byte histogram similarity block.
`timescale 1ns / 1ps
package bhs_pkg;

	localparam int COUNT_WIDTH_DEF   = 16;
	localparam int ALPHABET_SIZE_DEF = 256;
	localparam int BYTE_W            = 8;
	localparam int LEN_W             = 16;
	localparam int ENTRY_W           = 17;
	localparam int SUM_W             = 17;
	localparam int ALU_W             = 20;
	localparam int NUM_W             = 2 * SUM_W;
	localparam int DIV_CNT_W         = 6;

	typedef enum logic [1:0] {
		OP_FIRST  = 2'd0,
		OP_SECOND = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		alu_op_t          op;
	} alu_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_SUM,
		S_SUMT,
		S_SAME,
		S_DIV,
		S_DONE
	} state_t;

endpackage

### rtl/bhs_alu.sv
// Shared add/subtract unit used by the update, sum, compare and divide steps of the sequencer.
`timescale 1ns / 1ps
module bhs_alu (
	input  bhs_pkg::alu_req_t           req,
	output logic [bhs_pkg::ALU_W-1:0]   res
);
	import bhs_pkg::*;

	always_comb begin
		case (req.op)
			ALU_ADD: res = req.a + req.b;
			ALU_SUB: res = req.a - req.b;
			default: res = req.a;
		endcase
	end

endmodule

### rtl/bhs_hist_mem.sv
// Histogram memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
module bhs_hist_mem #(
	parameter int DEPTH = bhs_pkg::ALPHABET_SIZE_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [AW-1:0]                    rd_addr,
	output logic [bhs_pkg::ENTRY_W-1:0]      rd_data,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic [bhs_pkg::ENTRY_W-1:0]      wr_data,
	input  logic                             clr_all
);
	import bhs_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr_all) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

endmodule

### rtl/byte_histogram_similarity.sv
// Top level: byte histogram similarity sequencer.
`timescale 1ns / 1ps
// A string byte (operation 0 or 1) takes one histogram read and one write-back
// through the shared adder; a byte beyond max_len is dropped. A finish word
// makes one sweep of the histogram memory at one entry a cycle, a compare, and
// a 34-step restoring divide on the same adder, then hands the result to the
// output register. When either string is empty the divide is skipped. The
// output register lets the next word in while a result waits; finish clears
// all histogram valid bits at once as the result is loaded, so there is no
// clearing pass.
module byte_histogram_similarity #(
	parameter int COUNT_WIDTH   = bhs_pkg::COUNT_WIDTH_DEF,
	parameter int ALPHABET_SIZE = bhs_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bhs_pkg::LEN_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [bhs_pkg::BYTE_W-1:0]    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bhs_pkg::SUM_W-1:0]     similarity,
	output logic [bhs_pkg::SUM_W-1:0]     difference
);
	import bhs_pkg::*;

	localparam int AW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int LW   = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
	localparam int NTAB = 1 << BYTE_W;

	state_t                  state_q, state_d;
	logic [COUNT_WIDTH-1:0]  first_q, second_q;
	logic [LEN_W-1:0]        max_len_q;
	logic                    out_valid_q;

	logic [AW-1:0]           addr_q;
	alu_op_t                 upd_op_q;
	logic [SUM_W-1:0]        acc_q;
	logic [NUM_W-1:0]        num_q;
	logic [ALU_W-1:0]        rem_q;
	logic [DIV_CNT_W-1:0]    bit_q;
	logic [SUM_W-1:0]        similarity_q, difference_q;

	logic [AW-1:0]           idx_tab [NTAB];
	logic [AW-1:0]           idx;
	logic [LW-1:0]           cnt_max, lim;
	logic                    first_ok, second_ok, accept, out_load, last_addr;
	logic [SUM_W-1:0]        total;
	logic [SUM_W-1:0]        same;
	logic                    empty;
	logic [ALU_W-1:0]        rem_sh;

	logic                    rd_en, wr_en, clr_all;
	logic [AW-1:0]           rd_addr;
	logic [ENTRY_W-1:0]      rd_data;
	logic [ALU_W-1:0]        rd_ext;
	alu_req_t                alu_req;
	logic [ALU_W-1:0]        alu_res;

	for (genvar g = 0; g < NTAB; g++) begin : g_idx
		assign idx_tab[g] = AW'(g % ALPHABET_SIZE);
	end

	assign idx       = idx_tab[data_byte];
	assign cnt_max   = LW'((64'd1 << COUNT_WIDTH) - 64'd1);
	assign lim       = (LW'(max_len_q) < cnt_max) ? LW'(max_len_q) : cnt_max;
	assign first_ok  = LW'(first_q) < lim;
	assign second_ok = LW'(second_q) < lim;
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign last_addr = addr_q == AW'(ALPHABET_SIZE - 1);
	assign total     = SUM_W'(LEN_W'(first_q)) + SUM_W'(LEN_W'(second_q));
	assign empty     = (first_q == '0) || (second_q == '0);
	assign same      = alu_res[ALU_W-1] ? '0 : alu_res[SUM_W-1:0];
	assign rem_sh    = {rem_q[ALU_W-2:0], num_q[NUM_W-1]};
	assign rd_ext    = {{(ALU_W-ENTRY_W){rd_data[ENTRY_W-1]}}, rd_data};

	bhs_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	bhs_hist_mem #(
		.DEPTH (ALPHABET_SIZE),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (alu_res[ENTRY_W-1:0]),
		.clr_all (clr_all)
	);

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = addr_q;
		wr_en    = 1'b0;
		clr_all  = 1'b0;
		alu_req  = '{a: rd_ext, b: ALU_W'(1), op: upd_op_q};
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				rd_addr  = idx;
				if (in_valid) begin
					case (operation)
						OP_FIRST: begin
							if (first_ok) begin
								rd_en   = 1'b1;
								state_d = S_UPD;
							end
						end
						OP_SECOND: begin
							if (second_ok) begin
								rd_en   = 1'b1;
								state_d = S_UPD;
							end
						end
						OP_FINISH: state_d = S_SUM;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_UPD: begin
				wr_en   = 1'b1;
				state_d = S_IDLE;
			end
			S_SUM: begin
				rd_en   = 1'b1;
				alu_req = '{a: ALU_W'(acc_q), b: rd_ext,
					op: rd_data[ENTRY_W-1] ? ALU_SUB : ALU_ADD};
				if (last_addr) begin
					state_d = S_SUMT;
				end
			end
			S_SUMT: begin
				alu_req = '{a: ALU_W'(acc_q), b: rd_ext,
					op: rd_data[ENTRY_W-1] ? ALU_SUB : ALU_ADD};
				state_d = S_SAME;
			end
			S_SAME: begin
				alu_req = '{a: ALU_W'(total), b: ALU_W'(acc_q), op: ALU_SUB};
				state_d = empty ? S_DONE : S_DIV;
			end
			S_DIV: begin
				alu_req = '{a: rem_sh, b: ALU_W'({total, 1'b0}), op: ALU_SUB};
				if (bit_q == DIV_CNT_W'(NUM_W - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					clr_all = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= '0;
			second_q    <= '0;
			max_len_q   <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
			if (accept && (operation == OP_FIRST) && first_ok) begin
				first_q <= first_q + 1'b1;
			end
			if (accept && (operation == OP_SECOND) && second_ok) begin
				second_q <= second_q + 1'b1;
			end
			if (out_load) begin
				first_q  <= '0;
				second_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				upd_op_q <= (operation == OP_SECOND) ? ALU_SUB : ALU_ADD;
				acc_q    <= '0;
				if (accept && (operation == OP_FINISH)) begin
					addr_q <= '0;
				end else begin
					addr_q <= idx;
				end
			end
			S_SUM: begin
				addr_q <= addr_q + 1'b1;
				if (addr_q != '0) begin
					acc_q <= alu_res[SUM_W-1:0];
				end
			end
			S_SUMT: acc_q <= alu_res[SUM_W-1:0];
			S_SAME: begin
				num_q <= empty ? '0 : {same, total};
				rem_q <= '0;
				bit_q <= '0;
			end
			S_DIV: begin
				bit_q <= bit_q + 1'b1;
				if (alu_res[ALU_W-1]) begin
					rem_q <= rem_sh;
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end else begin
					rem_q <= alu_res;
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end
			end
			default: ;
		endcase
		if (out_load) begin
			similarity_q <= num_q[SUM_W-1:0];
			difference_q <= acc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign similarity = similarity_q;
	assign difference = difference_q;

endmodule
